/* rtl/core/rwce_pkg.sv */
// ----------------------------------------------------------------------------
// rwce_pkg
// Types and constants shared by the RIFF/WAVE chunk extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rwce_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;
  localparam logic [31:0] ROOT_MIN = 32'h0000_0024;

  localparam logic [32:0] ROOT_HDR_END = 33'd8;
  localparam logic [32:0] FORM_END     = 33'd12;
  localparam logic [31:0] HDR_LEN      = 32'd8;
  localparam logic [31:0] FMT_FULL     = 32'd18;
  localparam logic [31:0] FMT_CB_OFS   = 32'd16;
  localparam logic [4:0]  FMT_LAST     = 5'd17;

  typedef enum logic [2:0] {
    PH_ROOT,
    PH_FORM,
    PH_HDR,
    PH_PAY,
    PH_IDLE
  } phase_t;

  typedef enum logic [1:0] {
    SORT_FMT  = 2'd0,
    SORT_DATA = 2'd1,
    SORT_NONE = 2'd2
  } sort_t;

  typedef struct packed {
    logic hdr_shift;
    logic pos_inc;
    logic region_ld;
    logic hdr_clr;
    logic idx_inc;
    logic chunk_ld;
    logic left_dec;
    logic emit;
    logic pad_start;
    logic pad_zero;
  } rwce_cmd_t;

  typedef struct packed {
    logic root_done;
    logic root_ok;
    logic form_done;
    logic form_ok;
    logic room;
    logic hdr_done;
    logic hdr_fits;
    logic size_zero;
    logic tag_fmt;
    logic left_one;
    logic short_fmt;
    logic sort_none;
    logic pad_busy;
    logic out_free;
  } rwce_stat_t;

endpackage

`default_nettype wire

/* rtl/core/rwce_if.sv */
// ----------------------------------------------------------------------------
// rwce_if
// Valid/ready channels for file bytes in and chunk words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rwce_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       file_start;

  modport source (output valid, output file_byte, output file_start, input ready);
  modport sink   (input valid, input file_byte, input file_start, output ready);
endinterface

interface rwce_out_if;
  logic        valid;
  logic        ready;
  logic        chunk_sort;
  logic [7:0]  payload_byte;
  logic [31:0] byte_offset;
  logic        chunk_first;
  logic        chunk_last;
  logic        run_last;

  modport source (output valid, output chunk_sort, output payload_byte,
                  output byte_offset, output chunk_first, output chunk_last,
                  output run_last, input ready);
  modport sink   (input valid, input chunk_sort, input payload_byte,
                  input byte_offset, input chunk_first, input chunk_last,
                  input run_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/rwce_ctrl.sv */
// ----------------------------------------------------------------------------
// rwce_ctrl
// Parse phase state machine; issues datapath commands per accepted byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwce_ctrl import rwce_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_file_start,
  output logic       in_ready,
  input  rwce_stat_t stat,
  output rwce_cmd_t  cmd
);

  phase_t phase_r;
  phase_t phase_nxt;
  phase_t phase_eff;
  logic   acc;

  assign in_ready  = !stat.pad_busy && stat.out_free;
  assign acc       = in_valid && in_ready;
  assign phase_eff = in_file_start ? PH_ROOT : phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_ROOT;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      case (phase_eff)
        PH_ROOT: begin
          if (stat.root_done) begin
            phase_nxt = stat.root_ok ? PH_FORM : PH_IDLE;
          end else begin
            phase_nxt = PH_ROOT;
          end
        end
        PH_FORM: begin
          if (stat.form_done) begin
            phase_nxt = (stat.form_ok && stat.room) ? PH_HDR : PH_IDLE;
          end else begin
            phase_nxt = PH_FORM;
          end
        end
        PH_HDR: begin
          if (!stat.hdr_done) begin
            phase_nxt = PH_HDR;
          end else if (!stat.hdr_fits) begin
            phase_nxt = PH_IDLE;
          end else if (stat.size_zero) begin
            phase_nxt = stat.room ? PH_HDR : PH_IDLE;
          end else begin
            phase_nxt = PH_PAY;
          end
        end
        PH_PAY: begin
          if (stat.left_one) begin
            phase_nxt = stat.room ? PH_HDR : PH_IDLE;
          end else begin
            phase_nxt = PH_PAY;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    if (acc) begin
      case (phase_eff)
        PH_ROOT: begin
          cmd.hdr_shift = 1'b1;
          cmd.pos_inc   = 1'b1;
          cmd.region_ld = stat.root_done && stat.root_ok;
        end
        PH_FORM: begin
          cmd.hdr_shift = 1'b1;
          cmd.pos_inc   = 1'b1;
          cmd.hdr_clr   = stat.form_done && stat.form_ok && stat.room;
        end
        PH_HDR: begin
          cmd.hdr_shift = 1'b1;
          cmd.pos_inc   = 1'b1;
          cmd.idx_inc   = 1'b1;
          if (stat.hdr_done && stat.hdr_fits) begin
            cmd.chunk_ld = 1'b1;
            if (stat.size_zero) begin
              cmd.pad_start = stat.tag_fmt;
              cmd.pad_zero  = 1'b1;
              cmd.hdr_clr   = stat.room;
            end
          end
        end
        PH_PAY: begin
          cmd.pos_inc  = 1'b1;
          cmd.idx_inc  = 1'b1;
          cmd.left_dec = 1'b1;
          cmd.emit     = !stat.sort_none;
          if (stat.left_one) begin
            cmd.pad_start = stat.short_fmt;
            cmd.hdr_clr   = stat.room;
          end
        end
        default: cmd = '0;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rwce_dp.sv */
// ----------------------------------------------------------------------------
// rwce_dp
// Position, header shifter, chunk counters, pad generator and output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwce_dp import rwce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic [7:0]  in_file_byte,
  input  logic        in_file_start,
  input  rwce_cmd_t   cmd,
  output rwce_stat_t  stat,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        out_chunk_sort,
  output logic [7:0]  out_payload_byte,
  output logic [31:0] out_byte_offset,
  output logic        out_chunk_first,
  output logic        out_chunk_last,
  output logic        out_run_last
);

  logic [31:0] file_len_r;
  logic [32:0] pos_r;
  logic [63:0] shift_r;
  logic [32:0] region_r;
  logic [31:0] left_r;
  logic [31:0] idx_r;
  sort_t       sort_r;
  logic        fmt_short_r;
  logic        pad_act_r;
  logic [4:0]  pad_idx_r;
  logic        out_valid_r;
  logic        out_sort_r;
  logic [7:0]  out_byte_r;
  logic [31:0] out_off_r;
  logic        out_first_r;
  logic        out_last_r;
  logic        out_rlast_r;

  logic [32:0] pos_e;
  logic [63:0] shift_e;
  logic [63:0] shift_nxt;
  logic [32:0] pos_nxt;
  logic [31:0] idx_nxt;
  logic [31:0] hdr_tag;
  logic [31:0] hdr_size;
  sort_t       hdr_sort;
  logic        out_free;
  logic        pad_step;
  logic        zero_b;

  assign pos_e     = in_file_start ? '0 : pos_r;
  assign shift_e   = in_file_start ? '0 : shift_r;
  assign shift_nxt = {shift_e[55:0], in_file_byte};
  assign pos_nxt   = pos_e + 33'd1;
  assign idx_nxt   = idx_r + 32'd1;
  assign hdr_tag   = shift_nxt[63:32];
  assign hdr_size  = {shift_nxt[7:0], shift_nxt[15:8], shift_nxt[23:16], shift_nxt[31:24]};
  assign out_free  = !out_valid_r || out_ready;
  assign pad_step  = pad_act_r && out_free;

  always_comb begin
    if (hdr_tag == TAG_FMT) begin
      hdr_sort = SORT_FMT;
    end else if (hdr_tag == TAG_DATA) begin
      hdr_sort = SORT_DATA;
    end else begin
      hdr_sort = SORT_NONE;
    end
  end

  always_comb begin
    stat.root_done = pos_nxt >= ROOT_HDR_END;
    stat.root_ok   = (hdr_tag == TAG_RIFF) && (hdr_size >= ROOT_MIN) &&
                     ((ROOT_HDR_END + {1'b0, hdr_size}) <= {1'b0, file_len_r});
    stat.form_done = pos_nxt >= FORM_END;
    stat.form_ok   = shift_nxt[31:0] == TAG_WAVE;
    stat.room      = ({1'b0, pos_nxt} + {1'b0, ROOT_HDR_END}) <= {1'b0, region_r};
    stat.hdr_done  = idx_nxt >= HDR_LEN;
    stat.hdr_fits  = ({1'b0, pos_nxt} + {2'b0, hdr_size}) <= {1'b0, region_r};
    stat.size_zero = hdr_size == 32'd0;
    stat.tag_fmt   = hdr_sort == SORT_FMT;
    stat.left_one  = left_r == 32'd1;
    stat.short_fmt = (sort_r == SORT_FMT) && fmt_short_r;
    stat.sort_none = sort_r == SORT_NONE;
    stat.pad_busy  = pad_act_r;
    stat.out_free  = out_free;
  end

  assign zero_b = stat.short_fmt && (idx_r >= FMT_CB_OFS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_len_r  <= '0;
      pos_r       <= '0;
      pad_act_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        file_len_r <= cfg_wr_data;
      end
      if (cmd.pos_inc) begin
        pos_r <= pos_nxt;
      end
      if (cmd.pad_start) begin
        pad_act_r <= 1'b1;
      end else if (pad_step && pad_idx_r == FMT_LAST) begin
        pad_act_r <= 1'b0;
      end
      if (cmd.emit || pad_step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_clr || cmd.region_ld) begin
      shift_r <= '0;
    end else if (cmd.hdr_shift) begin
      shift_r <= shift_nxt;
    end
    if (cmd.region_ld) begin
      region_r <= ROOT_HDR_END + {1'b0, hdr_size};
    end
    if (cmd.hdr_clr || cmd.chunk_ld) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_nxt;
    end
    if (cmd.chunk_ld) begin
      sort_r      <= hdr_sort;
      fmt_short_r <= hdr_size < FMT_FULL;
      left_r      <= hdr_size;
    end else if (cmd.left_dec) begin
      left_r <= left_r - 32'd1;
    end
    if (cmd.pad_start) begin
      pad_idx_r <= cmd.pad_zero ? 5'd0 : idx_nxt[4:0];
    end else if (pad_step) begin
      pad_idx_r <= pad_idx_r + 5'd1;
    end
    if (cmd.emit) begin
      out_sort_r  <= sort_r[0];
      out_byte_r  <= zero_b ? 8'd0 : in_file_byte;
      out_off_r   <= idx_r;
      out_first_r <= idx_r == 32'd0;
      out_last_r  <= stat.left_one && !stat.short_fmt;
      out_rlast_r <= !cmd.pad_start;
    end else if (pad_step) begin
      out_sort_r  <= SORT_FMT[0];
      out_byte_r  <= 8'd0;
      out_off_r   <= {27'd0, pad_idx_r};
      out_first_r <= pad_idx_r == 5'd0;
      out_last_r  <= pad_idx_r == FMT_LAST;
      out_rlast_r <= pad_idx_r == FMT_LAST;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chunk_sort   = out_sort_r;
  assign out_payload_byte = out_byte_r;
  assign out_byte_offset  = out_off_r;
  assign out_chunk_first  = out_first_r;
  assign out_chunk_last   = out_last_r;
  assign out_run_last     = out_rlast_r;

endmodule

`default_nettype wire

/* rtl/core/riff_wave_chunk_extractor.sv */
// A payload word is loaded into the output register in the cycle after its byte is taken.
// Throughput: one file byte per cycle while the output is taken and no pad burst is running.
// A short format chunk adds a zero-pad burst of up to 18 words, one per cycle while the output is taken,
// with the input held off until the burst is out.
// Reset (rst_n low, synchronous): parse restarts at byte 0, file length clears to 0.
// ----------------------------------------------------------------------------
// riff_wave_chunk_extractor
// Walks a RIFF/WAVE byte stream and forwards fmt and data chunk words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module riff_wave_chunk_extractor import rwce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  rwce_in_if.sink     in_if,
  rwce_out_if.source  out_if
);

  rwce_cmd_t  cmd;
  rwce_stat_t stat;

  rwce_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_if.valid),
    .in_file_start (in_if.file_start),
    .in_ready      (in_if.ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  rwce_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_file_byte     (in_if.file_byte),
    .in_file_start    (in_if.file_start),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (out_if.ready),
    .out_valid        (out_if.valid),
    .out_chunk_sort   (out_if.chunk_sort),
    .out_payload_byte (out_if.payload_byte),
    .out_byte_offset  (out_if.byte_offset),
    .out_chunk_first  (out_if.chunk_first),
    .out_chunk_last   (out_if.chunk_last),
    .out_run_last     (out_if.run_last)
  );

endmodule

`default_nettype wire

/* rtl/core/rwce_chk.sv */
// ----------------------------------------------------------------------------
// rwce_chk
// Port-level checks for the chunk extractor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwce_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_chunk_sort,
  input logic [7:0]  out_payload_byte,
  input logic [31:0] out_byte_offset,
  input logic        out_chunk_first,
  input logic        out_chunk_last,
  input logic        out_run_last
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte) &&
      $stable(out_byte_offset) && $stable(out_chunk_sort))
    else $error("stalled output word changed");

  a_first_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_chunk_first == (out_byte_offset == 32'd0))
    else $error("chunk_first does not match offset zero");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chunk_last |-> out_run_last)
    else $error("chunk ended without ending the run");

  a_pad_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> !in_ready)
    else $error("input taken while a pad burst is pending");

endmodule

bind riff_wave_chunk_extractor rwce_chk u_rwce_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_chunk_sort   (out_if.chunk_sort),
  .out_payload_byte (out_if.payload_byte),
  .out_byte_offset  (out_if.byte_offset),
  .out_chunk_first  (out_if.chunk_first),
  .out_chunk_last   (out_if.chunk_last),
  .out_run_last     (out_if.run_last)
);

`default_nettype wire
